### design/xxrf_pkg.sv
package xxrf_pkg;

  localparam int DEPTH_DEF = 8;

  localparam int BYTE_W    = 8;
  localparam int FLOW_W    = 2;
  localparam int FILL_W    = 4;
  localparam int LIMIT_W   = 4;
  localparam int CFG_IDX_W = 2;

  // control characters below this code are skipped on consume, except CR and LF
  localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'd32;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'd13;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'd10;

  localparam logic KIND_RX      = 1'b0;
  localparam logic KIND_CONSUME = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT = 2'd1;

  localparam logic [LIMIT_W-1:0] UPPER_LIMIT_RESET = 4'd6;
  localparam logic [LIMIT_W-1:0] LOWER_LIMIT_RESET = 4'd2;

  typedef enum logic [FLOW_W-1:0] {
    FLOW_NONE = 2'd0,
    FLOW_XOFF = 2'd1,
    FLOW_XON  = 2'd2
  } flow_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] upper_limit;
    logic [LIMIT_W-1:0] lower_limit;
  } limits_t;

  typedef struct packed {
    logic              out_valid;
    logic [BYTE_W-1:0] out_byte;
    flow_t             flow_send;
    logic              rx_dropped;
    logic [FILL_W-1:0] fill_count;
  } result_t;

  function automatic logic is_skipped(input logic [BYTE_W-1:0] b);
    return (b < CTRL_LIMIT) && (b != CHAR_CR) && (b != CHAR_LF);
  endfunction

endpackage

### design/xxrf_in_if.sv
interface xxrf_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [xxrf_pkg::BYTE_W-1:0] in_byte;

  modport source (output valid, kind, in_byte, input ready);
  modport sink (input valid, kind, in_byte, output ready);
endinterface

### design/xxrf_out_if.sv
interface xxrf_out_if;
  logic                       valid;
  logic                       ready;
  logic                       out_valid;
  logic [xxrf_pkg::BYTE_W-1:0] out_byte;
  logic [xxrf_pkg::FLOW_W-1:0] flow_send;
  logic                       rx_dropped;
  logic [xxrf_pkg::FILL_W-1:0] fill_count;

  modport source (output valid, out_valid, out_byte, flow_send, rx_dropped, fill_count,
                  input ready);
  modport sink (input valid, out_valid, out_byte, flow_send, rx_dropped, fill_count,
                output ready);
endinterface

### design/xxrf_cfg_if.sv
interface xxrf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [xxrf_pkg::CFG_IDX_W-1:0] index;
  logic [xxrf_pkg::LIMIT_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/xxrf_ram.sv
module xxrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/xxrf_ctrl.sv
module xxrf_ctrl #(
  parameter int DEPTH = xxrf_pkg::DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  xxrf_in_if.sink                   rx_in,
  xxrf_out_if.source                rx_out,
  input  xxrf_pkg::limits_t         limits,
  output logic                      ram_we,
  output logic [$clog2(DEPTH)-1:0]  ram_waddr,
  output logic [xxrf_pkg::BYTE_W-1:0] ram_wdata,
  output logic                      ram_re,
  output logic [$clog2(DEPTH)-1:0]  ram_raddr,
  input  logic [xxrf_pkg::BYTE_W-1:0] ram_rdata
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > xxrf_pkg::LIMIT_W) ? CNT_W : xxrf_pkg::LIMIT_W;

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

  state_t             state;
  logic [IDX_W-1:0]   wr_idx;
  logic [IDX_W-1:0]   rd_idx;
  logic [CNT_W-1:0]   held;
  logic               stopped;
  logic               res_full;
  xxrf_pkg::result_t  res;

  logic               out_free;
  logic               in_acc;
  logic               is_rx;
  logic               full;
  logic               rx_store;
  logic [CNT_W-1:0]   held_rx;
  logic               rx_xoff;
  logic               cons_start;
  logic               cons_empty;
  logic               more;
  logic               fin;
  logic               xon;
  logic               res_load;
  logic [IDX_W-1:0]   wr_idx_next;
  logic [IDX_W-1:0]   rd_idx_next;

  assign out_free   = !res_full || rx_out.ready;
  assign rx_in.ready = (state == S_IDLE) && out_free;
  assign in_acc     = rx_in.valid && rx_in.ready;
  assign is_rx      = (rx_in.kind == xxrf_pkg::KIND_RX);
  assign full       = (held == CNT_W'(DEPTH));

  assign rx_store   = in_acc && is_rx && !stopped && !full;
  assign held_rx    = held + CNT_W'(rx_store);
  assign rx_xoff    = !stopped && (CMP_W'(held_rx) > CMP_W'(limits.upper_limit));

  assign cons_start = in_acc && !is_rx && (held != '0);
  assign cons_empty = in_acc && !is_rx && (held == '0);

  // keep popping while the byte just read is a control byte and more remain
  assign more = (state == S_POP) && xxrf_pkg::is_skipped(ram_rdata) && (held != '0);
  assign fin  = (state == S_POP) && !more && out_free;
  assign xon  = stopped && (CMP_W'(held) < CMP_W'(limits.lower_limit));

  // a new result enters the output register this cycle
  assign res_load = (in_acc && is_rx) || cons_empty || fin;

  assign wr_idx_next = (wr_idx == IDX_W'(DEPTH - 1)) ? '0 : wr_idx + 1'b1;
  assign rd_idx_next = (rd_idx == IDX_W'(DEPTH - 1)) ? '0 : rd_idx + 1'b1;

  assign ram_we    = rx_store;
  assign ram_waddr = wr_idx;
  assign ram_wdata = rx_in.in_byte;
  assign ram_re    = cons_start || more;
  assign ram_raddr = rd_idx;

  assign rx_out.valid      = res_full;
  assign rx_out.out_valid  = res.out_valid;
  assign rx_out.out_byte   = res.out_byte;
  assign rx_out.flow_send  = res.flow_send;
  assign rx_out.rx_dropped = res.rx_dropped;
  assign rx_out.fill_count = res.fill_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wr_idx   <= '0;
      rd_idx   <= '0;
      held     <= '0;
      stopped  <= 1'b0;
      res_full <= 1'b0;
    end else begin
      if (res_load) begin
        res_full <= 1'b1;
      end else if (rx_out.valid && rx_out.ready) begin
        res_full <= 1'b0;
      end

      if (rx_store) begin
        wr_idx <= wr_idx_next;
        held   <= held_rx;
      end

      if (ram_re) begin
        rd_idx <= rd_idx_next;
        held   <= held - 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (cons_start) begin
            state <= S_POP;
          end
        end
        S_POP: begin
          if (fin) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (in_acc && is_rx) begin
        res.out_valid  <= 1'b0;
        res.out_byte   <= '0;
        res.flow_send  <= rx_xoff ? xxrf_pkg::FLOW_XOFF : xxrf_pkg::FLOW_NONE;
        res.rx_dropped <= !rx_store;
        res.fill_count <= xxrf_pkg::FILL_W'(held_rx);
        if (rx_xoff) begin
          stopped <= 1'b1;
        end
      end else if (cons_empty) begin
        res.out_valid  <= 1'b0;
        res.out_byte   <= '0;
        res.flow_send  <= xxrf_pkg::FLOW_NONE;
        res.rx_dropped <= 1'b0;
        res.fill_count <= xxrf_pkg::FILL_W'(held);
      end else if (fin) begin
        res.out_valid  <= 1'b1;
        res.out_byte   <= ram_rdata;
        res.flow_send  <= xon ? xxrf_pkg::FLOW_XON : xxrf_pkg::FLOW_NONE;
        res.rx_dropped <= 1'b0;
        res.fill_count <= xxrf_pkg::FILL_W'(held);
        if (xon) begin
          stopped <= 1'b0;
        end
      end
    end
  end

endmodule

### design/xxrf_top.sv
// Receive FIFO with XON/XOFF flow control. Each word on rx_in is either a
// received byte (kind 0) to be stored in a DEPTH-entry ring, or a consume
// request (kind 1). Every accepted word yields exactly one result word on
// rx_out. A received byte is dropped and flagged with rx_dropped when the ring
// is full or while XOFF is held; after any received byte, while flow is running,
// XOFF is signalled on flow_send once the fill count exceeds upper_limit. A
// consume request pops one byte, then keeps popping while the byte just popped
// is a control character (below 32, other than CR and LF) and bytes remain,
// and returns the last byte popped with out_valid set; a consume on an empty
// ring returns out_valid 0. After a consume that popped, XON is signalled if
// XOFF was held and the fill count has fallen below lower_limit. fill_count
// carries the bytes held after the word, in four bits. A consume pops its
// bytes one after another through the single read port of the byte store
// with its registered read, and no new word is taken while it pops. A
// finished result is held in an output register, so the next word is taken
// while the result waits, as long as the previous result leaves in the same
// cycle. The limits are written over cfg (index 0 upper_limit, index 1
// lower_limit, other indices ignored), always ready; write them only while
// the block is idle. The byte store has no reset.
module xon_xoff_receive_fifo_top #(
  parameter int DEPTH = xxrf_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  xxrf_in_if.sink     rx_in,
  xxrf_out_if.source  rx_out,
  xxrf_cfg_if.sink    cfg
);

  localparam int IDX_W = $clog2(DEPTH);

  xxrf_pkg::limits_t             limits;
  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  logic [xxrf_pkg::BYTE_W-1:0]   ram_wdata;
  logic                          ram_re;
  logic [IDX_W-1:0]              ram_raddr;
  logic [xxrf_pkg::BYTE_W-1:0]   ram_rdata;

  // configuration writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.upper_limit <= xxrf_pkg::UPPER_LIMIT_RESET;
      limits.lower_limit <= xxrf_pkg::LOWER_LIMIT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == xxrf_pkg::REG_UPPER_LIMIT) begin
        limits.upper_limit <= cfg.data;
      end else if (cfg.index == xxrf_pkg::REG_LOWER_LIMIT) begin
        limits.lower_limit <= cfg.data;
      end
    end
  end

  // byte store: one write port for received bytes, one read port for pops
  xxrf_ram #(
    .WIDTH (xxrf_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ring pointers, fill count, flow state and the result register
  xxrf_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .rx_in     (rx_in),
    .rx_out    (rx_out),
    .limits    (limits),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule
